// File: hdl/assert_macros.svh
// Assertion macros used by the codec top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// File: hdl/qstc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quaternion codec package
// Widths, constants and payload types shared by the codec modules.
// ---------------------------------------------------------------------------
package qstc_pkg;
   localparam int unsigned NumComp = 4;
   localparam int unsigned NumLane = 3;
   localparam logic [19:0] EncMul = 20'd739895;
   localparam logic [15:0] DecMul = 16'd46439;
   localparam logic [8:0]  MagMax = 9'd511;
   localparam logic [14:0] Q15Max = 15'd32767;
   localparam logic [31:0] OneSq  = 32'd1073741824;

   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } mode_type;

   typedef struct packed {
      logic              mode;
      logic signed [15:0] comp_0;
      logic signed [15:0] comp_1;
      logic signed [15:0] comp_2;
      logic signed [15:0] comp_3;
      logic [31:0]       packed_word;
   } req_type;

   typedef struct packed {
      logic [31:0]       packed_word;
      logic signed [15:0] comp_0;
      logic signed [15:0] comp_1;
      logic signed [15:0] comp_2;
      logic signed [15:0] comp_3;
   } rsp_type;
endpackage

// File: hdl/qstc_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Codec channel interface
// Valid/ready channel carrying one payload item.
// ---------------------------------------------------------------------------
interface qstc_req_if import qstc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface qstc_rsp_if import qstc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/qstc_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Codec lane
// Quantises one component to a 10-bit field, or expands one field, and
// squares the decoded value. Two register stages.
// ---------------------------------------------------------------------------
module qstc_lane import qstc_pkg::*; (
   input  logic              clock,
   input  logic              advance,
   input  logic signed [15:0] comp_in,
   input  logic              negate,
   input  logic [9:0]        field_in,
   output logic [9:0]        field_out,
   output logic signed [15:0] value_out,
   output logic [29:0]       square_out
);
   logic signed [16:0] fold;
   logic [15:0]        mag;
   logic [35:0]        enc_prod_in, enc_prod_ff;
   logic               enc_neg_ff;
   logic [24:0]        dec_prod_in, dec_prod_ff;
   logic               dec_neg_ff;
   logic [10:0]        q;
   logic [14:0]        dmag;

   // Fold the sign and take the magnitude (up to 32768).
   assign fold = negate ? -17'(comp_in) : 17'(comp_in);
   assign mag  = fold[16] ? 16'(-fold) : fold[15:0];
   assign enc_prod_in = 36'(mag) * 36'(EncMul);
   assign dec_prod_in = 25'(field_in[8:0]) * 25'(DecMul);

   // Stage one: products.
   always_ff @(posedge clock) begin
      if (advance) begin
         enc_prod_ff <= enc_prod_in;
         enc_neg_ff  <= fold[16];
         dec_prod_ff <= dec_prod_in;
         dec_neg_ff  <= field_in[9];
      end
   end

   // Stage two: saturate, sign and square.
   assign q    = enc_prod_ff[35:25];
   assign dmag = dec_prod_ff[24:10];
   always_ff @(posedge clock) begin
      if (advance) begin
         field_out  <= {enc_neg_ff, (q > 11'(MagMax)) ? MagMax : q[8:0]};
         value_out  <= dec_neg_ff ? -16'(dmag) : 16'(dmag);
         square_out <= 30'(dmag) * 30'(dmag);
      end
   end
endmodule

// File: hdl/qstc_isqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pipelined square root
// Restoring integer square root, one result bit per stage over 16 stages.
// ---------------------------------------------------------------------------
module qstc_isqrt import qstc_pkg::*; (
   input  logic        clock,
   input  logic        advance,
   input  logic [30:0] rad_in,
   output logic [15:0] root_out
);
   logic [31:0] rem_ff  [1:15];
   logic [15:0] root_ff [1:16];
   logic [31:0] rem_in  [16];
   logic [15:0] root_in [16];

   // Each stage tries one result bit, from the top down.
   for (genvar s = 0; s < 16; s++) begin : g_stage
      logic [31:0] rem_cur;
      logic [15:0] root_cur;
      logic [31:0] trial;

      // The first stage works straight on the radicand.
      if (s == 0) begin : g_first
         assign rem_cur  = 32'(rad_in);
         assign root_cur = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[s];
         assign root_cur = root_ff[s];
      end

      assign trial = (32'(root_cur) << (16 - s)) | (32'd1 << (2 * (15 - s)));
      always_comb begin
         if (rem_cur >= trial) begin
            rem_in[s]  = rem_cur - trial;
            root_in[s] = root_cur | (16'd1 << (15 - s));
         end else begin
            rem_in[s]  = rem_cur;
            root_in[s] = root_cur;
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            root_ff[s+1] <= root_in[s];
         end
      end

      // The remainder is not needed after the last stage.
      if (s < 15) begin : g_rem
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[s+1] <= rem_in[s];
            end
         end
      end
   end

   assign root_out = root_ff[16];
endmodule

// File: hdl/quaternion_smallest_three_codec.sv
`timescale 1ns / 1ps
// An accepted item passes the lane stages, the radicand register, the square root and the output register to rsp.
// Throughput: one item per cycle while rsp does not stall; a 20-stage valid pipeline with a
// global advance, the square root's 16 stages setting the depth.
// Reset: synchronous, active high; clears the valid bits only, payload
// registers are left as they are.
// ---------------------------------------------------------------------------
// Quaternion smallest-three codec
// Three quantiser lanes, a largest-component search and a square-root
// pipeline, merged into one result item per input item.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module quaternion_smallest_three_codec import qstc_pkg::*; (
   input logic          clock,
   input logic          reset,
   qstc_req_if.sink     req,
   qstc_rsp_if.source   rsp
);
   localparam int unsigned Depth = 20;

   logic        advance;
   logic [Depth-1:0] vld_ff;
   logic [1:0]  idx;
   logic [15:0] mag [NumComp];
   logic signed [15:0] comps [NumComp];
   logic signed [15:0] others [NumLane];
   logic        negate;
   logic [9:0]  fld_out [NumLane];
   logic signed [15:0] val_out [NumLane];
   logic [29:0] sq_out [NumLane];
   logic [1:0]  idx_d_ff [2];
   logic        mode_d_ff [2];
   logic [31:0] sum;
   logic [30:0] rad_in, rad_ff;
   logic [15:0] root;
   // Side data travelling beside the square root (1 + 16 stages).
   logic [1:0]  idx_p_ff [17];
   logic        mode_p_ff [17];
   logic [31:0] word_p_ff [17];
   logic signed [15:0] val_p_ff [17][NumLane];
   rsp_type     out;

   // Pipeline moves when the output slot is free or taken.
   assign advance   = !vld_ff[Depth-1] || rsp.ready;
   assign req.ready = advance && !reset;

   // Largest magnitude, first wins on ties.
   assign comps = '{req.data.comp_0, req.data.comp_1, req.data.comp_2, req.data.comp_3};
   always_comb begin
      for (int i = 0; i < NumComp; i++)
         mag[i] = comps[i][15] ? 16'(-comps[i]) : comps[i];
      idx = 2'd0;
      for (int i = 1; i < NumComp; i++)
         if (mag[i] > mag[idx]) idx = 2'(i);
   end
   assign negate = !(comps[idx] > 16'sd0);
   always_comb begin
      for (int k = 0; k < NumLane; k++)
         others[k] = comps[(k < int'(idx)) ? k : k + 1];
   end

   for (genvar k = 0; k < NumLane; k++) begin : g_lane
      qstc_lane u_lane (
         .clock     (clock),
         .advance   (advance),
         .comp_in   (others[k]),
         .negate    (negate),
         .field_in  (req.data.packed_word[29-10*k -: 10]),
         .field_out (fld_out[k]),
         .value_out (val_out[k]),
         .square_out(sq_out[k])
      );
   end

   // Control beside the lane stages.
   always_ff @(posedge clock) begin
      if (advance) begin
         idx_d_ff[0]  <= (req.data.mode == MODE_DECODE) ? req.data.packed_word[31:30] : idx;
         mode_d_ff[0] <= req.data.mode;
         idx_d_ff[1]  <= idx_d_ff[0];
         mode_d_ff[1] <= mode_d_ff[0];
      end
   end

   // Radicand, clamped at zero.
   assign sum    = 32'(sq_out[0]) + 32'(sq_out[1]) + 32'(sq_out[2]);
   assign rad_in = (sum >= OneSq) ? 31'd0 : 31'(OneSq - sum);
   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff       <= rad_in;
         idx_p_ff[0]  <= idx_d_ff[1];
         mode_p_ff[0] <= mode_d_ff[1];
         word_p_ff[0] <= {idx_d_ff[1], fld_out[0], fld_out[1], fld_out[2]};
         for (int k = 0; k < NumLane; k++) val_p_ff[0][k] <= val_out[k];
         for (int s = 1; s < 17; s++) begin
            idx_p_ff[s]  <= idx_p_ff[s-1];
            mode_p_ff[s] <= mode_p_ff[s-1];
            word_p_ff[s] <= word_p_ff[s-1];
            val_p_ff[s]  <= val_p_ff[s-1];
         end
      end
   end

   qstc_isqrt u_isqrt (
      .clock   (clock),
      .advance (advance),
      .rad_in  (rad_ff),
      .root_out(root)
   );

   // Merge: put the rebuilt component in its slot.
   always_comb begin
      logic signed [15:0] dc [NumComp];
      logic signed [15:0] d;
      int k;
      d = root[15] ? 16'(Q15Max) : root;
      k = 0;
      for (int i = 0; i < NumComp; i++) begin
         if (i == int'(idx_p_ff[16])) dc[i] = d;
         else begin
            dc[i] = val_p_ff[16][k[1:0]];
            k = k + 1;
         end
      end
      if (mode_p_ff[16] == MODE_DECODE) begin
         out = '{32'd0, dc[0], dc[1], dc[2], dc[3]};
      end else begin
         out = '{word_p_ff[16], 16'sd0, 16'sd0, 16'sd0, 16'sd0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp.data <= out;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Depth-2:0], req.valid};
      end
   end
   assign rsp.valid = vld_ff[Depth-1];

   `CHK_IMPLY(a_stall_hold, clock, reset, rsp.valid && !rsp.ready, !req.ready, "input taken while output stalled")
   `CHK_NEXT(a_valid_kept, clock, reset, rsp.valid && !rsp.ready, rsp.valid, "result dropped under stall")
   `CHK_IMPLY(a_enc_zero, clock, reset, rsp.valid && rsp.data.packed_word != 32'd0, rsp.data.comp_0 == 16'sd0 && rsp.data.comp_1 == 16'sd0, "encode result carries components")
endmodule

// File: tb/sv/tb_quaternion_smallest_three_codec.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quaternion smallest-three codec testbench
// Sends encode and decode items with random gaps on both sides, predicts each
// result with an independent model of the codec and compares every field of
// every result item in order.
// ---------------------------------------------------------------------------
module tb_quaternion_smallest_three_codec;
   import qstc_pkg::*;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned Latency    = 20;

   logic clock;
   logic reset;
   logic failed;
   logic hold_off;
   int unsigned cycle_count;
   int unsigned hold_count;

   qstc_req_if req_ch ();
   qstc_rsp_if rsp_ch ();

   rsp_type expected_codes[$];

   quaternion_smallest_three_codec dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // Clock generation.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Cycle counter with a timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("quaternion_smallest_three_codec test failed");
         $finish;
      end
   end

   // Quantise one folded component into a sign bit over a 9-bit magnitude.
   function automatic logic [9:0] quantise(input logic signed [16:0] v);
      logic [16:0] mag;
      logic [40:0] prod;
      logic [8:0]  q;
      mag  = v[16] ? -v : v;
      prod = mag * 41'd739895;
      q    = (prod[40:25] > 16'd511) ? 9'd511 : prod[33:25];
      return {v[16], q};
   endfunction

   // Rebuild one component from a packed field.
   function automatic logic signed [16:0] dequantise(input logic [9:0] f);
      logic [25:0] prod;
      logic signed [16:0] v;
      prod = f[8:0] * 26'd46439;
      v = $signed({1'b0, prod[25:10]});
      return f[9] ? -v : v;
   endfunction

   // Bitwise integer square root.
   function automatic logic [15:0] int_sqrt(input logic [31:0] x);
      logic [31:0] res;
      logic [31:0] b;
      res = 0;
      b = 32'h4000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res[15:0];
   endfunction

   // Work out the result item that one request item produces.
   function automatic rsp_type codec_result(input req_type r);
      rsp_type o;
      logic signed [16:0] c[4];
      logic signed [16:0] s[3];
      logic [16:0] best;
      logic [16:0] m;
      logic [1:0]  idx;
      logic [63:0] sum;
      logic [31:0] root;
      int k;
      o = '0;
      if (r.mode == MODE_ENCODE) begin
         c[0] = r.comp_0; c[1] = r.comp_1; c[2] = r.comp_2; c[3] = r.comp_3;
         idx = 0;
         best = c[0][16] ? -c[0] : c[0];
         for (int i = 1; i < 4; i++) begin
            m = c[i][16] ? -c[i] : c[i];
            if (m > best) begin
               best = m;
               idx = 2'(i);
            end
         end
         o.packed_word[31:30] = idx;
         k = 0;
         for (int i = 0; i < 4; i++) begin
            if (i != idx) begin
               o.packed_word[20 - 10*k +: 10] =
                  quantise(c[idx] > 0 ? c[i] : -c[i]);
               k++;
            end
         end
      end else begin
         idx = r.packed_word[31:30];
         sum = 0;
         for (int j = 0; j < 3; j++) begin
            s[j] = dequantise(r.packed_word[20 - 10*j +: 10]);
            sum = sum + 64'(s[j]) * 64'(s[j]);
         end
         root = (sum >= 64'd1073741824) ? 0 : int_sqrt(32'(64'd1073741824 - sum));
         if (root > 32767) root = 32767;
         k = 0;
         for (int i = 0; i < 4; i++) begin
            if (i == idx) c[i] = 17'(root);
            else begin
               c[i] = s[k];
               k++;
            end
         end
         o.comp_0 = c[0][15:0]; o.comp_1 = c[1][15:0];
         o.comp_2 = c[2][15:0]; o.comp_3 = c[3][15:0];
      end
      return o;
   endfunction

   // Random gap length: mostly short, a few long.
   function automatic int unsigned gap_length();
      if ($urandom_range(9) == 0) return $urandom_range(40, 10);
      if ($urandom_range(2) == 0) return 0;
      return $urandom_range(3);
   endfunction

   // Receiver: random stalls, plus a long hold-off when asked.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            hold_count = hold_count + 1;
            if (hold_count >= 200) hold_off = 1'b0;
         end else if ($urandom_range(3) == 0) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (expected_codes.size() == 0) begin
            $error("result item with no expectation: %h", got);
            failed <= 1'b1;
         end else begin
            want = expected_codes.pop_front();
            if (got.packed_word !== want.packed_word) begin
               $error("packed_out: expected %h, got %h", want.packed_word, got.packed_word);
               failed <= 1'b1;
            end
            if (got.comp_0 !== want.comp_0) begin
               $error("comp_0_out: expected %0d, got %0d", want.comp_0, got.comp_0);
               failed <= 1'b1;
            end
            if (got.comp_1 !== want.comp_1) begin
               $error("comp_1_out: expected %0d, got %0d", want.comp_1, got.comp_1);
               failed <= 1'b1;
            end
            if (got.comp_2 !== want.comp_2) begin
               $error("comp_2_out: expected %0d, got %0d", want.comp_2, got.comp_2);
               failed <= 1'b1;
            end
            if (got.comp_3 !== want.comp_3) begin
               $error("comp_3_out: expected %0d, got %0d", want.comp_3, got.comp_3);
               failed <= 1'b1;
            end
         end
      end
   end

   // Offer one item until it is accepted, after an optional gap.
   task automatic send_item(input req_type r, input int unsigned gap);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      expected_codes.push_back(codec_result(r));
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   function automatic req_type encode_item(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] c, input logic [15:0] d);
      req_type r;
      r = '0;
      r.mode = MODE_ENCODE;
      r.comp_0 = a; r.comp_1 = b; r.comp_2 = c; r.comp_3 = d;
      r.packed_word = $urandom;
      return r;
   endfunction

   function automatic req_type decode_item(input logic [31:0] w);
      req_type r;
      r = '0;
      r.mode = MODE_DECODE;
      r.comp_0 = 16'($urandom); r.comp_1 = 16'($urandom); r.comp_2 = 16'($urandom);
      r.comp_3 = 16'($urandom);
      r.packed_word = w;
      return r;
   endfunction

   // Extremes, ties, sign folding and the decode special cases.
   task automatic test_directed();
      send_item(encode_item(16'h7fff, 0, 0, 0), 0);
      send_item(encode_item(16'h8000, 16'h1234, 16'hedcb, 0), 0);
      send_item(encode_item(0, 0, 0, 0), 1);
      send_item(encode_item(16'h4000, 16'hc000, 16'h4000, 16'hc000), 0);
      send_item(encode_item(16'hc000, 16'h4000, 16'h4000, 16'h4000), 0);
      send_item(encode_item(100, 16'h8000, 16'h7fff, 16'h8000), 0);
      send_item(encode_item(16'h8000, 16'h8000, 16'h8000, 16'h8000), 2);
      send_item(encode_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 0);
      send_item(encode_item(1, 16'hffff, 2, 16'hfffe), 0);
      send_item(encode_item(16'hffff, 16'hffff, 0, 1), 0);
      send_item(decode_item(32'h0000_0000), 0);
      send_item(decode_item(32'hffff_ffff), 0);
      send_item(decode_item(32'h7fdf_f7fd), 0);
      send_item(decode_item(32'h2008_0200), 0);
      send_item(decode_item({2'd3, 10'd511, 10'd511, 10'd0}), 3);
      send_item(decode_item({2'd1, 10'd0, 10'd0, 10'd1}), 0);
      send_item(decode_item({2'd2, 10'd300, 10'd300, 10'd300}), 0);
      send_item(decode_item({2'd0, 10'd512, 10'd1023, 10'd512}), 0);
   endtask

   // Random items: near-unit quaternions mixed with raw patterns.
   task automatic test_random(input int unsigned count);
      logic [15:0] v[4];
      req_type r;
      for (int unsigned n = 0; n < count; n++) begin
         for (int i = 0; i < 4; i++) v[i] = 16'($urandom);
         if ($urandom_range(3) != 0) begin
            v[$urandom_range(3)] = $urandom_range(1) ? 16'($urandom_range(32767, 16000))
                                                     : 16'(-$urandom_range(32768, 16000));
            for (int i = 0; i < 4; i++) if ($urandom_range(1)) v[i] = $signed(v[i]) >>> 1;
         end
         if ($urandom_range(1)) r = encode_item(v[0], v[1], v[2], v[3]);
         else r = decode_item($urandom);
         send_item(r, gap_length());
      end
   endtask

   // Back-to-back items while the receiver holds off, so the pipeline fills.
   task automatic test_backpressure();
      hold_count = 0;
      hold_off = 1'b1;
      for (int n = 0; n < 60; n++)
         send_item($urandom_range(1) ? encode_item(16'($urandom), 16'($urandom),
                                                   16'($urandom), 16'($urandom))
                                     : decode_item($urandom), 0);
   endtask

   initial begin
      failed = 1'b0;
      hold_off = 1'b0;
      hold_count = 0;
      cycle_count = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(1800);
      req_ch.valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
      if (!failed) begin
         $display("quaternion_smallest_three_codec test passed");
      end else begin
         $display("quaternion_smallest_three_codec test failed");
      end
      $finish;
   end
endmodule
